// ===== rtl/iale_pkg.sv =====
// Package for the indexed array list engine.
// Holds the operation and status codes, controller states and the command struct.
// No dependencies.
package iale_pkg;

    localparam int unsigned POS_W   = 5;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COUNT_W = 5;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_INSERT = 2'd2,
        OP_REMOVE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_EMPTY = 1'b0,
        S_HOLD  = 1'b1
    } t_state;

    typedef struct packed {
        logic exec;
    } t_cmd;

endpackage

// ===== rtl/indexed_array_list_engine_unit.sv =====
// Top level of the indexed array list engine.
// Instantiates iale_ctrl and iale_dp; depends on iale_pkg.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one word of operation,
//   position and word_in. Output channel: o_out_valid / i_out_stall carry
//   one result word of word_out, status and entry_count per input word.
//   A word moves at a clock edge where valid is high and stall is low.
//   The result is registered at the edge that accepts the input.
//   Throughput is one word per cycle while i_out_stall is low; read,
//   overwrite, insert and remove each complete at the accepting edge
//   since every entry register loads from its neighbor in parallel.
//   While a result is held and i_out_stall is high, o_in_stall is raised
//   and the held result stays unchanged. A new input is taken in the same
//   cycle the held result is taken.
//   Reset (i_rst_n low, synchronous) empties the list and drops the held
//   result. Entries are not cleared; only entries below the count are read.
//   CAPACITY sets the number of entry registers.
module indexed_array_list_engine_unit #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_operation,
    input  logic [iale_pkg::POS_W-1:0]         i_position,
    input  logic signed [iale_pkg::WORD_W-1:0] i_word_in,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [iale_pkg::WORD_W-1:0] o_word_out,
    output logic [1:0]                         o_status,
    output logic [iale_pkg::COUNT_W-1:0]       o_entry_count
);
    import iale_pkg::*;

    t_cmd cmd;

    iale_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    iale_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_operation   (i_operation),
        .i_position    (i_position),
        .i_word_in     (i_word_in),
        .o_word_out    (o_word_out),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

`ifndef SYNTHESIS
    a_stall_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> (o_in_stall && !cmd.exec))
        else $error("input taken while result stalled");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> (o_entry_count == COUNT_W'(CAPACITY)))
        else $error("full status with count below capacity");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_word_out == '0))
        else $error("nonzero word on error");
`endif

endmodule

// ===== rtl/iale_ctrl.sv =====
// Controller for the indexed array list engine.
// Tracks whether a result word is held and issues the execute command.
// Depends on iale_pkg.
module iale_ctrl (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_out_stall,
    output logic         o_in_stall,
    output logic         o_out_valid,
    output iale_pkg::t_cmd o_cmd
);
    import iale_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_in_stall  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd.exec  = 1'b0;
        n_state     = r_state;
        unique case (r_state)
            S_EMPTY: begin
                o_cmd.exec = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                o_out_valid = 1'b1;
                o_in_stall  = i_out_stall;
                o_cmd.exec  = i_in_valid && !i_out_stall;
                if (!i_out_stall && !i_in_valid) begin
                    n_state = S_EMPTY;
                end
            end
            default: begin
                n_state = S_EMPTY;
            end
        endcase
    end

endmodule

// ===== rtl/iale_dp.sv =====
// Datapath for the indexed array list engine.
// Entry registers with neighbor shifting, entry count and result registers.
// Depends on iale_pkg.
module iale_dp #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  iale_pkg::t_cmd                i_cmd,
    input  logic [1:0]                    i_operation,
    input  logic [iale_pkg::POS_W-1:0]    i_position,
    input  logic signed [iale_pkg::WORD_W-1:0] i_word_in,
    output logic signed [iale_pkg::WORD_W-1:0] o_word_out,
    output logic [1:0]                    o_status,
    output logic [iale_pkg::COUNT_W-1:0]  o_entry_count
);
    import iale_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned IW = $clog2(CAPACITY);
    localparam int unsigned MW = (CW > POS_W) ? CW : POS_W;

    logic [WORD_W-1:0]  r_entries [CAPACITY];
    logic [WORD_W-1:0]  n_entries [CAPACITY];
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [WORD_W-1:0]  r_word_out;
    logic [WORD_W-1:0]  n_word_out;
    t_status            r_status;
    t_status            n_status;
    logic [COUNT_W-1:0] r_count_out;

    logic [MW-1:0] pos_ext;
    logic [MW-1:0] count_ext;
    logic [IW-1:0] idx;
    logic [WORD_W-1:0] cur_word;
    logic in_range;
    logic ins_range;
    logic is_full;
    logic do_write;
    logic do_insert;
    logic do_remove;
    t_op  op;

    assign op        = t_op'(i_operation);
    assign pos_ext   = MW'(i_position);
    assign count_ext = MW'(r_count);
    assign idx       = pos_ext[IW-1:0];
    assign cur_word  = r_entries[idx];
    assign in_range  = pos_ext < count_ext;
    assign ins_range = pos_ext <= count_ext;
    assign is_full   = count_ext == MW'(CAPACITY);

    always_comb begin
        n_word_out = '0;
        n_status   = ST_OK;
        n_count    = r_count;
        do_write   = 1'b0;
        do_insert  = 1'b0;
        do_remove  = 1'b0;
        unique case (op)
            OP_INSERT: begin
                if (!ins_range) begin
                    n_status = ST_RANGE;
                end else if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    do_insert = 1'b1;
                    n_count   = r_count + CW'(1);
                end
            end
            OP_READ: begin
                if (!in_range) begin
                    n_status = ST_RANGE;
                end else begin
                    n_word_out = cur_word;
                end
            end
            OP_WRITE: begin
                if (!in_range) begin
                    n_status = ST_RANGE;
                end else begin
                    n_word_out = cur_word;
                    do_write   = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (!in_range) begin
                    n_status = ST_RANGE;
                end else begin
                    n_word_out = cur_word;
                    do_remove  = 1'b1;
                    n_count    = r_count - CW'(1);
                end
            end
            default: begin
                n_status = ST_RANGE;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_entries[i] = r_entries[i];
            if (do_insert) begin
                if (MW'(i) == pos_ext) begin
                    n_entries[i] = i_word_in;
                end else if ((i > 0) && (MW'(i) > pos_ext)) begin
                    n_entries[i] = r_entries[(i > 0) ? i - 1 : 0];
                end
            end else if (do_remove) begin
                if ((i + 1 < CAPACITY) && (MW'(i) >= pos_ext)) begin
                    n_entries[i] = r_entries[(i + 1 < CAPACITY) ? i + 1 : i];
                end
            end else if (do_write && (MW'(i) == pos_ext)) begin
                n_entries[i] = i_word_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_entries[i] <= n_entries[i];
            end
            r_word_out  <= n_word_out;
            r_status    <= n_status;
            r_count_out <= COUNT_W'(n_count);
        end
    end

    assign o_word_out    = r_word_out;
    assign o_status      = r_status;
    assign o_entry_count = r_count_out;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for indexed_array_list_engine_unit (read, overwrite, insert, remove).
// A clocked driver and monitor surround the block, and a predictor of the list state checks
// every result. Depends on iale_pkg and the RTL of the block.
module tb_top;
    import iale_pkg::*;

    localparam int LIST_CAP    = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 225;
    localparam int PRINT_LIMIT = 40;

    typedef struct {
        t_op                op;
        logic [POS_W-1:0]   pos;
        logic signed [31:0] word;
    } t_list_cmd;

    typedef struct {
        logic signed [31:0] word;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_list_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [1:0]                i_operation = '0;
    logic [POS_W-1:0]          i_position = '0;
    logic signed [WORD_W-1:0]  i_word_in = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic signed [WORD_W-1:0]  o_word_out;
    logic [1:0]                o_status;
    logic [COUNT_W-1:0]        o_entry_count;

    t_list_cmd          cmd_q[$];
    t_list_result       result_q[$];
    logic signed [31:0] list_mem[LIST_CAP];
    logic [COUNT_W-1:0] list_len = '0;
    int                 gen_len = 0;
    bit                 grow = 1'b1;
    bit                 in_fire = 1'b0;
    int                 idle_pct = 0;
    int                 stall_pct = 0;
    int                 n_queued = 0;
    int                 n_taken = 0;
    int                 err_count = 0;
    int                 cycles = 0;

    indexed_array_list_engine_unit #(.CAPACITY(LIST_CAP)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_position    (i_position),
        .i_word_in     (i_word_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_word_out    (o_word_out),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    always #6 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        if (err_count < PRINT_LIMIT) begin
            $display("MISMATCH cycle %0d: %s", cycles, msg);
        end
        err_count++;
    endtask

    task automatic apply_list_op(input t_op op, input logic [POS_W-1:0] pos,
                                 input logic signed [31:0] w, output t_list_result r);
        int k;
        r.word = '0;
        r.status = ST_OK;
        if (op == OP_INSERT) begin
            if (pos > list_len) begin
                r.status = ST_RANGE;
            end else if (list_len >= LIST_CAP) begin
                r.status = ST_FULL;
            end else begin
                for (k = list_len; k > pos; k--) list_mem[k] = list_mem[k-1];
                list_mem[pos] = w;
                list_len++;
            end
        end else if (pos >= list_len) begin
            r.status = ST_RANGE;
        end else begin
            r.word = list_mem[pos];
            if (op == OP_WRITE) begin
                list_mem[pos] = w;
            end else if (op == OP_REMOVE) begin
                for (k = pos; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
                list_len--;
            end
        end
        r.count = list_len;
    endtask

    task automatic add_cmd(input t_op op, input int pos, input logic signed [31:0] w);
        t_list_cmd c;
        c.op = op;
        c.pos = pos[POS_W-1:0];
        c.word = w;
        cmd_q.push_back(c);
        n_queued++;
        if (op == OP_INSERT && pos <= gen_len && gen_len < LIST_CAP) gen_len++;
        if (op == OP_REMOVE && pos < gen_len) gen_len--;
    endtask

    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return -32'sd1;
            3: return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_random_cmd();
        int   r;
        int   pos;
        t_op  op;
        r = $urandom_range(0, 99);
        if (grow) begin
            op = (r < 45) ? OP_INSERT : (r < 60) ? OP_REMOVE : (r < 80) ? OP_READ : OP_WRITE;
        end else begin
            op = (r < 15) ? OP_INSERT : (r < 55) ? OP_REMOVE : (r < 78) ? OP_READ : OP_WRITE;
        end
        if ($urandom_range(0, 99) < 15) begin
            pos = $urandom_range(0, 31);
        end else if (op == OP_INSERT) begin
            pos = $urandom_range(0, gen_len);
        end else if (gen_len > 0) begin
            pos = $urandom_range(0, gen_len - 1);
        end else begin
            pos = $urandom_range(0, 31);
        end
        add_cmd(op, pos, pick_word());
        if (gen_len >= LIST_CAP) grow = 1'b0;
        else if (gen_len == 0) grow = 1'b1;
        else if ($urandom_range(0, 29) == 0) grow = ~grow;
    endtask

    task automatic wait_drained();
        while (n_taken != n_queued || result_q.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // driver
    always @(negedge i_clk) begin
        t_list_cmd c;
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (cmd_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                c = cmd_q.pop_front();
                i_operation <= c.op;
                i_position  <= c.pos;
                i_word_in   <= c.word;
                i_in_valid  <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // monitor: check the result word leaving, then predict the word entering
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    want = result_q.pop_front();
                    if (o_word_out !== want.word)
                        report_mismatch($sformatf("word_out %0d, expected %0d",
                                                  o_word_out, want.word));
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_status, want.status));
                    if (o_entry_count !== want.count)
                        report_mismatch($sformatf("entry_count %0d, expected %0d",
                                                  o_entry_count, want.count));
                end
            end
            in_fire = i_in_valid && !o_in_stall;
            if (in_fire) begin
                apply_list_op(t_op'(i_operation), i_position, i_word_in, want);
                result_q.push_back(want);
                n_taken++;
            end
        end else begin
            in_fire = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int i;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 0;
        stall_pct = 0;
        add_cmd(OP_READ, 0, 32'sd5);
        add_cmd(OP_REMOVE, 0, 32'sd5);
        add_cmd(OP_INSERT, 1, 32'sd5);
        for (i = 0; i < LIST_CAP; i++) begin
            add_cmd(OP_INSERT, (i % 3 == 0) ? 0 : (i % 3 == 1) ? i : i / 2,
                    (i == 0) ? 32'sh7FFF_FFFF : (i == 1) ? 32'sh8000_0000 :
                    (i == 2) ? -32'sd1 : (i == 3) ? 32'sd0 : $urandom);
        end
        add_cmd(OP_INSERT, 7, 32'sd9);
        add_cmd(OP_INSERT, 20, 32'sd9);
        add_cmd(OP_READ, 15, 32'sd0);
        add_cmd(OP_WRITE, 0, 32'sh5A5A_A5A5);
        add_cmd(OP_REMOVE, 0, 32'sd0);
        add_cmd(OP_REMOVE, 14, 32'sd0);
        add_cmd(OP_READ, 31, 32'sd0);
        grow = 1'b0;
        for (i = 0; i < PHASE_ITEMS; i++) add_random_cmd();
        wait_drained();

        idle_pct = 51;
        stall_pct = 0;
        for (i = 0; i < PHASE_ITEMS; i++) add_random_cmd();
        wait_drained();

        idle_pct = 0;
        stall_pct = 51;
        for (i = 0; i < PHASE_ITEMS; i++) add_random_cmd();
        wait_drained();

        idle_pct = 37;
        stall_pct = 37;
        for (i = 0; i < PHASE_ITEMS; i++) add_random_cmd();
        wait_drained();

        repeat (4) @(negedge i_clk);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
